### hdl/agdvd_pkg.sv
package agdvd_pkg;

    // Width of a variable index and of the configuration registers.
    localparam int IDX_BITS = 31;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int ERR_BITS = 3;

    // Varint byte layout.
    localparam int PAYLOAD_BITS = 7;
    localparam int CONT_BIT = 7;

    // Saturation value of the gate index.
    localparam logic [IDX_BITS-1:0] IDX_MAX = {IDX_BITS{1'b1}};
    localparam logic [IDX_BITS-1:0] IDX_RESET = IDX_BITS'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIRST_GATE = 1'b0,
        CFG_LAST_GATE  = 1'b1
    } cfg_idx_t;

    // Error codes of a decoded gate.
    typedef enum logic [ERR_BITS-1:0] {
        ERR_OK        = 3'd0,
        ERR_DELTA0    = 3'd1,
        ERR_DELTA1    = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_PAST_LAST = 3'd4
    } err_t;

endpackage

### hdl/agdvd_in_if.sv
interface agdvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       section_start;

    modport source (output valid, output data_byte, output section_start, input ready);
    modport sink (input valid, input data_byte, input section_start, output ready);
endinterface

### hdl/agdvd_out_if.sv
interface agdvd_out_if #(
    parameter int LIT_BITS = 32
);
    logic                valid;
    logic                ready;
    logic [LIT_BITS-1:0] gate_literal;
    logic [LIT_BITS-1:0] left_literal;
    logic [LIT_BITS-1:0] right_literal;
    logic [2:0]          error_code;
    logic                last_gate;

    modport source (
        output valid, output gate_literal, output left_literal, output right_literal,
        output error_code, output last_gate, input ready
    );
    modport sink (
        input valid, input gate_literal, input left_literal, input right_literal,
        input error_code, input last_gate, output ready
    );
endinterface

### hdl/agdvd_cfg_if.sv
interface agdvd_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/agdvd_varint.sv
module agdvd_varint #(
    parameter int LIT_BITS = 32,
    parameter int MAX_VARINT_BYTES = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                restart,
    input  logic [7:0]          data_byte,
    output logic [LIT_BITS-1:0] acc_now,
    output logic                ovf_now
);
    import agdvd_pkg::*;

    localparam int POS_BITS = $clog2(MAX_VARINT_BYTES + 1);
    localparam int WIDE_BITS = LIT_BITS + PAYLOAD_BITS * MAX_VARINT_BYTES;
    localparam int SHIFT_BITS = $clog2(WIDE_BITS);

    logic [LIT_BITS-1:0]  acc_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic                 ovf_reg;
    logic [LIT_BITS-1:0]  acc_base;
    logic [POS_BITS-1:0]  pos_base;
    logic                 ovf_base;
    logic [POS_BITS-1:0]  pos_now;
    logic [SHIFT_BITS-1:0] shift_amt;
    logic [WIDE_BITS-1:0] shifted;

    always_comb
    begin
        acc_base  = restart ? '0 : acc_reg;
        pos_base  = restart ? '0 : pos_reg;
        ovf_base  = restart ? 1'b0 : ovf_reg;
        shift_amt = SHIFT_BITS'(pos_base) * SHIFT_BITS'(PAYLOAD_BITS);
        shifted   = WIDE_BITS'(data_byte[PAYLOAD_BITS-1:0]) << shift_amt;
        if (pos_base >= POS_BITS'(MAX_VARINT_BYTES))
        begin
            // Too many bytes: the payload is dropped and the position saturates.
            ovf_now = 1'b1;
            acc_now = acc_base;
            pos_now = pos_base;
        end
        else
        begin
            // Any payload bit that lands above the literal width is lost.
            ovf_now = ovf_base | (|shifted[WIDE_BITS-1:LIT_BITS]);
            acc_now = acc_base | shifted[LIT_BITS-1:0];
            pos_now = pos_base + POS_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (data_byte[CONT_BIT])
            begin
                acc_reg <= acc_now;
                pos_reg <= pos_now;
                ovf_reg <= ovf_now;
            end
            else
            begin
                acc_reg <= '0;
                pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

endmodule

### hdl/and_gate_delta_varint_decoder.sv
// Output: a gate appears on the output in the cycle after the transfer of the last
// byte of its second varint.
// Throughput: one byte per cycle; the output register frees the input side unless a
// finished gate is waiting and the sink holds ready low.
// Reset: all decoding state clears, both gate index registers read one, the gate index
// starts at one, and no result is pending.
module and_gate_delta_varint_decoder #(
    parameter int LIT_BITS = 32,
    parameter int MAX_VARINT_BYTES = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    agdvd_in_if.sink    byte_stream,
    agdvd_out_if.source gate_stream,
    agdvd_cfg_if.sink   cfg
);
    import agdvd_pkg::*;

    // Configuration registers. The first gate only reaches the gate index when a
    // byte with section_start is transferred; at reset the index loads one.
    logic [IDX_BITS-1:0] first_gate_reg;
    logic [IDX_BITS-1:0] last_gate_reg;

    // Pair decoding state.
    logic [IDX_BITS-1:0] gate_idx_reg;
    logic [IDX_BITS-1:0] gate_idx_next;
    logic                second_half_reg;
    logic                second_half_next;
    logic [LIT_BITS-1:0] held_left_reg;
    logic [LIT_BITS-1:0] held_left_next;
    err_t                held_err_reg;
    err_t                held_err_next;

    // Output register.
    logic                out_valid_reg;
    logic [LIT_BITS-1:0] gate_lit_reg;
    logic [LIT_BITS-1:0] left_lit_reg;
    logic [LIT_BITS-1:0] right_lit_reg;
    err_t                err_reg;
    logic                last_reg;

    logic                take;
    logic                restart;
    logic                varint_end;
    logic                emit;
    logic [IDX_BITS-1:0] gate_idx_base;
    logic                second_half_base;
    logic [LIT_BITS-1:0] held_left_base;
    err_t                held_err_base;
    logic [LIT_BITS-1:0] gate_lit;
    logic [LIT_BITS-1:0] acc_now;
    logic                ovf_now;
    logic [LIT_BITS-1:0] right_lit;
    err_t                emit_err;

    // A new byte is taken whenever the output register is empty or drains in
    // this same cycle, so a waiting gate never blocks the byte stream by itself.
    assign byte_stream.ready = !out_valid_reg || gate_stream.ready;
    assign take    = byte_stream.valid && byte_stream.ready;
    assign restart = byte_stream.section_start;
    assign cfg.ready = 1'b1;

    // The varint unit folds the current byte into the running value and reports
    // the value and overflow flag as they stand with this byte included.
    agdvd_varint #(
        .LIT_BITS         (LIT_BITS),
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_varint (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .restart   (restart),
        .data_byte (byte_stream.data_byte),
        .acc_now   (acc_now),
        .ovf_now   (ovf_now)
    );

    always_comb
    begin
        // A section start restarts the pair state before this byte is used.
        gate_idx_base    = restart ? first_gate_reg : gate_idx_reg;
        second_half_base = restart ? 1'b0 : second_half_reg;
        held_left_base   = restart ? '0 : held_left_reg;
        held_err_base    = restart ? ERR_OK : held_err_reg;

        gate_lit   = LIT_BITS'({gate_idx_base, 1'b0});
        right_lit  = held_left_base - acc_now;
        varint_end = !byte_stream.data_byte[CONT_BIT];
        emit       = take && varint_end && second_half_base;

        // Error priority: past the last gate, then whatever the first varint left,
        // then overflow of the second varint, then a second delta that is too big.
        if (gate_idx_base > last_gate_reg)
            emit_err = ERR_PAST_LAST;
        else if (held_err_base != ERR_OK)
            emit_err = held_err_base;
        else if (ovf_now)
            emit_err = ERR_OVERFLOW;
        else if (acc_now > held_left_base)
            emit_err = ERR_DELTA1;
        else
            emit_err = ERR_OK;

        gate_idx_next    = gate_idx_base;
        second_half_next = second_half_base;
        held_left_next   = held_left_base;
        held_err_next    = held_err_base;
        if (varint_end)
        begin
            if (!second_half_base)
            begin
                // First delta done: keep the left literal and its error.
                second_half_next = 1'b1;
                held_left_next   = gate_lit - acc_now;
                if (ovf_now)
                    held_err_next = ERR_OVERFLOW;
                else if (acc_now > gate_lit)
                    held_err_next = ERR_DELTA0;
                else
                    held_err_next = ERR_OK;
            end
            else
            begin
                // Pair complete: advance the index, saturating at its top value.
                second_half_next = 1'b0;
                held_left_next   = '0;
                held_err_next    = ERR_OK;
                if (gate_idx_base != IDX_MAX)
                    gate_idx_next = gate_idx_base + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_gate_reg  <= IDX_RESET;
            last_gate_reg   <= IDX_RESET;
            gate_idx_reg    <= IDX_RESET;
            second_half_reg <= 1'b0;
            held_left_reg   <= '0;
            held_err_reg    <= ERR_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_idx_t'(cfg.index))
                    CFG_FIRST_GATE: first_gate_reg <= cfg.data[IDX_BITS-1:0];
                    CFG_LAST_GATE:  last_gate_reg  <= cfg.data[IDX_BITS-1:0];
                    default:        ;
                endcase
            end
            if (take)
            begin
                gate_idx_reg    <= gate_idx_next;
                second_half_reg <= second_half_next;
                held_left_reg   <= held_left_next;
                held_err_reg    <= held_err_next;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (gate_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            gate_lit_reg  <= gate_lit;
            left_lit_reg  <= held_left_base;
            right_lit_reg <= right_lit;
            err_reg       <= emit_err;
            last_reg      <= (gate_idx_base == last_gate_reg);
        end
    end

    assign gate_stream.valid         = out_valid_reg;
    assign gate_stream.gate_literal  = gate_lit_reg;
    assign gate_stream.left_literal  = left_lit_reg;
    assign gate_stream.right_literal = right_lit_reg;
    assign gate_stream.error_code    = err_reg;
    assign gate_stream.last_gate     = last_reg;

endmodule
